// File: hdl/flfs_pkg.sv
// flfs_pkg: shared types, codes and defaults for the four-level feedback scheduler.
// No dependencies; used by flfs_cell, flfs_level and the top level.
package flfs_pkg;

    localparam int MAX_PROCS_DEF = 64;
    localparam int LEVELS_DEF    = 4;

    localparam int PID_W    = 6;
    localparam int CMD_W    = 2;
    localparam int OUTC_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int SLICE_W  = 18;
    localparam int STATUS_W = 2;
    localparam int QUANT_W  = 16;

    localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAKE     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_FINISH   = 2'd2
    } flfs_cmd_t;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_EXPIRED = 2'd0,
        OUTC_BLOCKED = 2'd1,
        OUTC_ENDED   = 2'd2
    } flfs_outc_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_NOT_RUNNING = 2'd2
    } flfs_status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PID_W-1:0]  pid_in;
        logic [OUTC_W-1:0] outcome;
    } req_item_t;

    typedef struct packed {
        logic [PID_W-1:0]    pid_out;
        logic [LEVEL_W-1:0]  level_out;
        logic [SLICE_W-1:0]  slice_out;
        logic                idle;
        logic [STATUS_W-1:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [PID_W-1:0] pid;
    } flfs_lvl_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } flfs_lvl_stat_t;

endpackage

// File: hdl/flfs_cell.sv
// flfs_cell: one queue slot; shifts towards the head on a pop or loads a new pid.
// Depends on flfs_pkg.
module flfs_cell (
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        load,
    input  logic [flfs_pkg::PID_W-1:0]  nbr_pid,
    input  logic [flfs_pkg::PID_W-1:0]  load_pid,
    output logic [flfs_pkg::PID_W-1:0]  pid
);

    logic [flfs_pkg::PID_W-1:0] pid_reg;
    logic [flfs_pkg::PID_W-1:0] pid_next;

    always_comb
    begin
        pid_next = pid_reg;
        if (shift)
        begin
            pid_next = nbr_pid;
        end
        else if (load)
        begin
            pid_next = load_pid;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg <= pid_next;
    end

    assign pid = pid_reg;

endmodule

// File: hdl/flfs_level.sv
// flfs_level: one ready queue built as a chain of flfs_cell slots, head at slot 0.
// Depends on flfs_pkg and flfs_cell.
module flfs_level #(
    parameter int DEPTH = flfs_pkg::MAX_PROCS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  flfs_pkg::flfs_lvl_ctl_t     ctl,
    output logic [flfs_pkg::PID_W-1:0]  head_pid,
    output flfs_pkg::flfs_lvl_stat_t    stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [flfs_pkg::PID_W-1:0] cell_pid [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [flfs_pkg::PID_W-1:0] nbr;
        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_pid[i+1];
        end

        flfs_cell u_cell (
            .clk      (clk),
            .shift    (ctl.pop),
            .load     (ctl.push && (count_reg == CNT_W'(i))),
            .nbr_pid  (nbr),
            .load_pid (ctl.pid),
            .pid      (cell_pid[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head_pid   = cell_pid[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !stat.full)
        else $error("push into full level");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !stat.empty)
        else $error("pop from empty level");

endmodule

// File: hdl/four_level_feedback_scheduler_unit.sv
// four_level_feedback_scheduler_unit: multilevel feedback queue scheduler top level.
// Depends on flfs_pkg and flfs_level (which uses flfs_cell).
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  req      | req_valid/req_stall| cmd, pid_in, outcome  (req_item_t)
//  rsp      | rsp_valid/rsp_stall| pid_out, level_out, slice_out, idle,
//           |                    | status  (rsp_item_t)
//  cfg      | cfg_we             | cfg_data -> base_quantum
//
// One item per cycle while req_stall is low; its result appears in the output register the cycle after.
// Priority pick, queue update and slice multiply are all worked out in the same cycle.
// Reset empties all levels and clears the running process; no clearing pass.
// While a result is held by rsp_stall, req_stall is raised.
module four_level_feedback_scheduler_unit #(
    parameter int MAX_PROCS = flfs_pkg::MAX_PROCS_DEF,
    parameter int LEVELS    = flfs_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  flfs_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output flfs_pkg::rsp_item_t           rsp_item,
    input  logic                          cfg_we,
    input  logic [flfs_pkg::QUANT_W-1:0]  cfg_data
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PROD_W = LVL_W + 1 + flfs_pkg::QUANT_W;

    logic [flfs_pkg::QUANT_W-1:0] base_q_reg;
    logic [flfs_pkg::PID_W-1:0]   run_pid_reg,   run_pid_next;
    logic [LVL_W-1:0]             run_lvl_reg,   run_lvl_next;
    logic                         run_valid_reg, run_valid_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    flfs_pkg::rsp_item_t          rsp_item_reg,  rsp_item_next;

    flfs_pkg::flfs_lvl_ctl_t      lvl_ctl  [LEVELS];
    flfs_pkg::flfs_lvl_stat_t     lvl_stat [LEVELS];
    logic [flfs_pkg::PID_W-1:0]   head_pid [LEVELS];

    logic                         accept;
    logic                         any_ready;
    logic [LVL_W-1:0]             pick_lvl;
    logic [LVL_W-1:0]             down_lvl;
    logic [LVL_W-1:0]             grant_lvl;
    logic [LVL_W:0]               grant_mul;
    logic [PROD_W-1:0]            grant_prod;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        flfs_level #(
            .DEPTH (MAX_PROCS)
        ) u_level (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lvl_ctl[l]),
            .head_pid (head_pid[l]),
            .stat     (lvl_stat[l])
        );
    end

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // lowest-numbered (highest-priority) non-empty level
    always_comb
    begin
        any_ready = 1'b0;
        pick_lvl  = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (!lvl_stat[l].empty)
            begin
                any_ready = 1'b1;
                pick_lvl  = LVL_W'(l);
            end
        end
    end

    assign down_lvl   = (run_lvl_reg == LVL_W'(LEVELS - 1)) ? run_lvl_reg
                                                             : LVL_W'(run_lvl_reg + 1'b1);
    assign grant_lvl  = run_valid_reg ? run_lvl_reg : pick_lvl;
    assign grant_mul  = (LVL_W + 1)'(grant_lvl) + 1'b1;
    assign grant_prod = PROD_W'(grant_mul) * PROD_W'(base_q_reg);

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            lvl_ctl[l] = '0;
        end
        run_pid_next   = run_pid_reg;
        run_lvl_next   = run_lvl_reg;
        run_valid_next = run_valid_reg;
        rsp_item_next  = '0;

        if (accept)
        begin
            case (req_item.cmd)
                flfs_pkg::CMD_WAKE:
                begin
                    if (lvl_stat[0].full)
                    begin
                        rsp_item_next.status = flfs_pkg::ST_FULL;
                    end
                    else
                    begin
                        lvl_ctl[0].push = 1'b1;
                        lvl_ctl[0].pid  = req_item.pid_in;
                    end
                end
                flfs_pkg::CMD_DISPATCH:
                begin
                    if (run_valid_reg)
                    begin
                        rsp_item_next.pid_out   = run_pid_reg;
                        rsp_item_next.level_out = flfs_pkg::LEVEL_W'(run_lvl_reg);
                        rsp_item_next.slice_out = flfs_pkg::SLICE_W'(grant_prod);
                    end
                    else if (any_ready)
                    begin
                        lvl_ctl[pick_lvl].pop   = 1'b1;
                        run_pid_next            = head_pid[pick_lvl];
                        run_lvl_next            = pick_lvl;
                        run_valid_next          = 1'b1;
                        rsp_item_next.pid_out   = head_pid[pick_lvl];
                        rsp_item_next.level_out = flfs_pkg::LEVEL_W'(pick_lvl);
                        rsp_item_next.slice_out = flfs_pkg::SLICE_W'(grant_prod);
                    end
                    else
                    begin
                        rsp_item_next.idle = 1'b1;
                    end
                end
                flfs_pkg::CMD_FINISH:
                begin
                    if (!run_valid_reg)
                    begin
                        rsp_item_next.status = flfs_pkg::ST_NOT_RUNNING;
                    end
                    else
                    begin
                        run_valid_next = 1'b0;
                        if (req_item.outcome == flfs_pkg::OUTC_EXPIRED)
                        begin
                            if (lvl_stat[down_lvl].full)
                            begin
                                rsp_item_next.status = flfs_pkg::ST_FULL;
                            end
                            else
                            begin
                                lvl_ctl[down_lvl].push = 1'b1;
                                lvl_ctl[down_lvl].pid  = run_pid_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    rsp_item_next = '0;
                end
            endcase
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_q_reg    <= flfs_pkg::QUANT_RESET;
            run_pid_reg   <= '0;
            run_lvl_reg   <= '0;
            run_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_q_reg <= cfg_data;
            end
            run_pid_reg   <= run_pid_next;
            run_lvl_reg   <= run_lvl_next;
            run_valid_reg <= run_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item gave no result");

    a_run_ends_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(run_valid_reg) |-> $past(accept && req_item.cmd == flfs_pkg::CMD_FINISH))
        else $error("running process lost without finish");

    a_idle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_item.cmd == flfs_pkg::CMD_DISPATCH && !run_valid_reg && !any_ready)
        |=> (rsp_item_reg.idle && !run_valid_reg))
        else $error("empty dispatch not reported idle");

    a_run_starts_on_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_valid_reg) |-> $past(accept && req_item.cmd == flfs_pkg::CMD_DISPATCH))
        else $error("process started without dispatch");

endmodule
